>>> sv/multitone_byte_modulator_macros.svh
// assertion macros shared by the multitone byte modulator modules
`ifndef MULTITONE_BYTE_MODULATOR_MACROS_SVH
`define MULTITONE_BYTE_MODULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// plain property, checked on every clock edge out of reset
`define MTBM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// same-cycle implication, checked out of reset
`define MTBM_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define MTBM_ASSERT(label, prop)
`define MTBM_ASSERT_IMP(label, pre, post)
`endif
`endif

>>> sv/mtbm_pkg.sv
`timescale 1ns / 1ps
// constants, types and sine tables shared by the multitone byte modulator
package mtbm_pkg;

    // symbol and index geometry
    localparam int unsigned SYMBOL_SAMPLES = 400;
    localparam int unsigned IDX_W = 9;
    localparam int unsigned SYM_W = 13;
    localparam logic [SYM_W-1:0] SYM_CONST = SYM_W'(SYMBOL_SAMPLES);
    localparam int unsigned REDUCE_STEPS = ((1 << IDX_W) - 1) / SYMBOL_SAMPLES;

    // tone set: eight data tones, then the clock tone, then the pilot tone
    localparam int unsigned NUM_BITS = 8;
    localparam int unsigned NUM_TONES = 10;
    localparam int unsigned HALF_TONES = NUM_TONES / 2;
    localparam int unsigned TONE_CLK = 8;
    localparam int unsigned TONE_PILOT = 9;
    localparam int unsigned MAX_PERIOD = 64;
    localparam int unsigned PHASE_W = 6;
    localparam int unsigned TONE_PERIOD [NUM_TONES] =
        '{38, 31, 24, 20, 16, 13, 10, 8, 64, 6};
    localparam int unsigned TONE_WEIGHT [NUM_TONES] =
        '{152, 31, 24, 20, 16, 13, 10, 8, 64, 6};

    // ceiling reciprocals for j mod period, exact for j below 512
    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned RECIP_ONE = 1 << RECIP_SHIFT;
    localparam int unsigned RQ_W = IDX_W + RECIP_SHIFT + 1;
    localparam int unsigned TONE_RECIP [NUM_TONES] = '{
        (RECIP_ONE + 38 - 1) / 38, (RECIP_ONE + 31 - 1) / 31,
        (RECIP_ONE + 24 - 1) / 24, (RECIP_ONE + 20 - 1) / 20,
        (RECIP_ONE + 16 - 1) / 16, (RECIP_ONE + 13 - 1) / 13,
        (RECIP_ONE + 10 - 1) / 10, (RECIP_ONE + 8 - 1) / 8,
        (RECIP_ONE + 64 - 1) / 64, (RECIP_ONE + 6 - 1) / 6};

    // output scaling: data gain 32766, clock gain 3270 * 344, common divisor 344 * 2^15
    localparam int unsigned OUT_FULL = 32766;
    localparam int unsigned CLOCK_AMPL = 3270;
    localparam int unsigned WEIGHT_SUM = 344;
    localparam int unsigned DATA_GAIN = OUT_FULL;
    localparam int unsigned CLOCK_GAIN = CLOCK_AMPL * WEIGHT_SUM;
    localparam int unsigned GAIN_W = 21;
    localparam int unsigned ACC_W = 25;
    localparam int unsigned PROD_W = ACC_W + GAIN_W + 1;
    localparam int unsigned MAG_W = 39;
    localparam int unsigned SCALE_TWOS = 3;
    localparam int unsigned SCALE_ODD = WEIGHT_SUM >> SCALE_TWOS;
    localparam int unsigned SCALE_POW = 15 + SCALE_TWOS;
    localparam int unsigned N_W = MAG_W - SCALE_POW;
    localparam int unsigned DIV_SHIFT = N_W + 6;
    localparam int unsigned DIV_RECIP = (1 << DIV_SHIFT) / SCALE_ODD;
    localparam int unsigned RECIP_W = 22;
    localparam int unsigned Q_W = N_W + RECIP_W - DIV_SHIFT;

    // sine table generation in Q30 / Q15
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // configuration register map
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W = IDX_W;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GATE_START = 1'b0,
        REG_GATE_END   = 1'b1
    } cfg_reg_t;
    localparam logic [IDX_W-1:0] GATE_START_RST = 9'd169;
    localparam logic [IDX_W-1:0] GATE_END_RST = 9'd367;

    typedef logic signed [15:0] sample_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef sample_t sine_row_t [MAX_PERIOD];

    // gate window handed to the tone generator
    typedef struct packed {
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] stop;
    } gate_cfg_t;

    // per-sample tone values after lookup
    typedef struct packed {
        logic                            func;
        logic [NUM_BITS-1:0]             data;
        sample_t [NUM_TONES-1:0]         tone;
    } tone_word_t;

    // multiplier operand after mixing
    typedef struct packed {
        logic                    func;
        logic signed [ACC_W-1:0] operand;
    } mix_word_t;

    // division by one of the tone periods, elaboration only
    function automatic longint unsigned div_period(longint unsigned a, int unsigned p);
        longint unsigned res;
        case (p)
            38:      res = a / 38;
            31:      res = a / 31;
            24:      res = a / 24;
            20:      res = a / 20;
            16:      res = a / 16;
            13:      res = a / 13;
            10:      res = a / 10;
            8:       res = a / 8;
            64:      res = a / 64;
            6:       res = a / 6;
            default: res = '0;
        endcase
        return res;
    endfunction

    // Q15 sine of 2*pi*k/p by quadrant fold and a Q30 Horner series
    function automatic sample_t sine_q15(int unsigned k, int unsigned p);
        longint unsigned n;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        sample_t res;
        n = 4 * longint'(k);
        quad = div_period(n, p);
        rem = n - quad * p;
        if (quad[0])
            rem = p - rem;
        f = div_period(rem << 30, p);
        x = (f * HALFPI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = ONE_Q30 - x2 / 110;
        t = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
            q = 64'd32767;
        res = sample_t'(q[15:0]);
        if (quad >= 2)
            res = -res;
        return res;
    endfunction

    // one table row per tone, entries past the period unused
    function automatic sine_row_t make_row(int unsigned tone);
        sine_row_t row;
        for (int unsigned k = 0; k < MAX_PERIOD; k++)
        begin
            row[k] = (k < TONE_PERIOD[tone]) ? sine_q15(k, TONE_PERIOD[tone]) : '0;
        end
        return row;
    endfunction

    localparam sine_row_t SINE_ROW [NUM_TONES] = '{
        make_row(0), make_row(1), make_row(2), make_row(3), make_row(4),
        make_row(5), make_row(6), make_row(7), make_row(8), make_row(9)};

endpackage

>>> sv/multitone_byte_modulator.sv
`timescale 1ns / 1ps
// Multitone byte modulator top level: gate registers and the nine-stage sample pipeline.
// An accepted word passes through the tone generator, mixer and scaler stage registers in order to out_valid.
// Throughput: one word per cycle while out_stall is low; the nine pipeline registers each hold one word.
// A stalled output holds its word; empty stages behind it still fill.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the gate to 169..367.
module multitone_byte_modulator
    import mtbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [NUM_BITS-1:0]  data_byte,
    input  logic [IDX_W-1:0]     sample_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sample_t              audio_sample
);

    logic [IDX_W-1:0] gate_start_reg;
    logic [IDX_W-1:0] gate_end_reg;
    gate_cfg_t        gate;

    logic       tone_valid;
    logic       tone_stall;
    tone_word_t tone_word;
    logic       mix_valid;
    logic       mix_stall;
    mix_word_t  mix_word;

    // gate window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_start_reg <= GATE_START_RST;
            gate_end_reg   <= GATE_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GATE_START: gate_start_reg <= cfg_data;
                REG_GATE_END:   gate_end_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign gate.start = gate_start_reg;
    assign gate.stop  = gate_end_reg;

    // phase and sine lookup
    mtbm_tone_gen u_tone_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .data_byte    (data_byte),
        .sample_index (sample_index),
        .gate         (gate),
        .tone_valid   (tone_valid),
        .tone_stall   (tone_stall),
        .tone_word    (tone_word)
    );

    // weighted mix
    mtbm_mixer u_mixer (
        .clk        (clk),
        .rst_n      (rst_n),
        .tone_valid (tone_valid),
        .tone_stall (tone_stall),
        .tone_word  (tone_word),
        .mix_valid  (mix_valid),
        .mix_stall  (mix_stall),
        .mix_word   (mix_word)
    );

    // output scaling
    mtbm_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .mix_valid    (mix_valid),
        .mix_stall    (mix_stall),
        .mix_word     (mix_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .audio_sample (audio_sample)
    );

endmodule

>>> sv/mtbm_tone_gen.sv
`timescale 1ns / 1ps
// index reduction, per-tone phase and sine lookup: three pipeline stages
`include "multitone_byte_modulator_macros.svh"
module mtbm_tone_gen
    import mtbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [NUM_BITS-1:0] data_byte,
    input  logic [IDX_W-1:0]    sample_index,
    input  gate_cfg_t           gate,
    output logic                tone_valid,
    input  logic                tone_stall,
    output tone_word_t          tone_word
);

    logic [2:0] v_reg;
    logic [2:0] hold;

    logic [IDX_W-1:0]     j_reg, j_next;
    logic                 func_a_reg;
    logic [NUM_BITS-1:0]  data_a_reg;

    phase_t [NUM_TONES-1:0] k_reg, k_next;
    logic                   gated_reg, gated_next;
    logic                   func_b_reg;
    logic [NUM_BITS-1:0]    data_b_reg;

    tone_word_t word_reg, word_next;

    logic [RQ_W-1:0]  quo;
    logic [IDX_W-1:0] rem;

    // a stage holds only when it has a word and the next one holds
    always_comb
    begin
        hold[2] = v_reg[2] & tone_stall;
        hold[1] = v_reg[1] & hold[2];
        hold[0] = v_reg[0] & hold[1];
    end

    assign in_stall = hold[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (!hold[0])
                v_reg[0] <= in_valid;
            if (!hold[1])
                v_reg[1] <= v_reg[0];
            if (!hold[2])
                v_reg[2] <= v_reg[1];
        end
    end

    // stage a: fold the sample index into the symbol
    always_comb
    begin
        j_next = sample_index;
        for (int s = 0; s < REDUCE_STEPS; s++)
        begin
            if (SYM_W'(j_next) >= SYM_CONST)
                j_next = j_next - SYM_CONST[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            j_reg      <= j_next;
            func_a_reg <= func;
            data_a_reg <= data_byte;
        end
    end

    // stage b: phase of every tone by reciprocal multiply, and the gate window
    always_comb
    begin
        quo = '0;
        rem = '0;
        for (int t = 0; t < NUM_TONES; t++)
        begin
            quo = (RQ_W'(j_reg) * RQ_W'(TONE_RECIP[t])) >> RECIP_SHIFT;
            rem = j_reg - IDX_W'(quo) * IDX_W'(TONE_PERIOD[t]);
            k_next[t] = PHASE_W'(rem);
        end
        gated_next = (j_reg >= gate.start) && (j_reg <= gate.stop);
    end

    always_ff @(posedge clk)
    begin
        if (!hold[1])
        begin
            k_reg      <= k_next;
            gated_reg  <= gated_next;
            func_b_reg <= func_a_reg;
            data_b_reg <= data_a_reg;
        end
    end

    // stage c: sine lookup, clock tone silenced inside the gate
    always_comb
    begin
        word_next.func = func_b_reg;
        word_next.data = data_b_reg;
        for (int t = 0; t < NUM_TONES; t++)
        begin
            word_next.tone[t] = SINE_ROW[t][k_reg[t]];
        end
        if (gated_reg)
            word_next.tone[TONE_CLK] = '0;
    end

    always_ff @(posedge clk)
    begin
        if (!hold[2])
            word_reg <= word_next;
    end

    assign tone_valid = v_reg[2];
    assign tone_word  = word_reg;

    // folded index stays inside the symbol
    `MTBM_ASSERT_IMP(a_index_folded, v_reg[0], SYM_W'(j_reg) < SYM_CONST)
    // pilot phase stays below its period
    `MTBM_ASSERT_IMP(a_pilot_phase, v_reg[1], k_reg[TONE_PILOT] < PHASE_W'(TONE_PERIOD[TONE_PILOT]))

endmodule

>>> sv/mtbm_mixer.sv
`timescale 1ns / 1ps
// weighted tone sum and selection of the scaling operand: two pipeline stages
module mtbm_mixer
    import mtbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tone_valid,
    output logic       tone_stall,
    input  tone_word_t tone_word,
    output logic       mix_valid,
    input  logic       mix_stall,
    output mix_word_t  mix_word
);

    logic [1:0] v_reg;
    logic [1:0] hold;

    logic                    func_a_reg;
    sample_t                 clk_a_reg;
    logic signed [ACC_W-1:0] g0_reg, g0_next;
    logic signed [ACC_W-1:0] g1_reg, g1_next;

    mix_word_t word_reg, word_next;

    logic [NUM_TONES-1:0]    tone_on;
    logic signed [ACC_W-1:0] s_ext;
    logic signed [ACC_W-1:0] w;
    logic signed [ACC_W-1:0] term [NUM_TONES];

    // stall chain with bubble collapse
    always_comb
    begin
        hold[1] = v_reg[1] & mix_stall;
        hold[0] = v_reg[0] & hold[1];
    end

    assign tone_stall = hold[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (!hold[0])
                v_reg[0] <= tone_valid;
            if (!hold[1])
                v_reg[1] <= v_reg[0];
        end
    end

    // stage a: constant-weight products, summed in two halves
    always_comb
    begin
        tone_on = {{(NUM_TONES - NUM_BITS){1'b1}}, tone_word.data};
        s_ext = '0;
        w = '0;
        for (int t = 0; t < NUM_TONES; t++)
        begin
            s_ext = ACC_W'(sample_t'(tone_word.tone[t]));
            w = ACC_W'(TONE_WEIGHT[t]);
            term[t] = tone_on[t] ? s_ext * w : '0;
        end
        g0_next = '0;
        g1_next = '0;
        for (int t = 0; t < HALF_TONES; t++)
        begin
            g0_next = g0_next + term[t];
            g1_next = g1_next + term[t + HALF_TONES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
        begin
            func_a_reg <= tone_word.func;
            clk_a_reg  <= sample_t'(tone_word.tone[TONE_CLK]);
            g0_reg     <= g0_next;
            g1_reg     <= g1_next;
        end
    end

    // stage b: full sum in data mode, bare clock tone in clock mode
    always_comb
    begin
        word_next.func = func_a_reg;
        if (func_a_reg)
            word_next.operand = ACC_W'(clk_a_reg);
        else
            word_next.operand = g0_reg + g1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!hold[1])
            word_reg <= word_next;
    end

    assign mix_valid = v_reg[1];
    assign mix_word  = word_reg;

endmodule

>>> sv/mtbm_scaler.sv
`timescale 1ns / 1ps
// gain multiply and truncating division by 344 * 2^15: four pipeline stages
`include "multitone_byte_modulator_macros.svh"
module mtbm_scaler
    import mtbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mix_valid,
    output logic      mix_stall,
    input  mix_word_t mix_word,
    output logic      out_valid,
    input  logic      out_stall,
    output sample_t   audio_sample
);

    logic [3:0] v_reg;
    logic [3:0] hold;
    logic [3:0] func_reg;

    logic signed [GAIN_W:0]   gain;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic [PROD_W-1:0] mag;
    logic              neg_b_reg, neg_next;
    logic [N_W-1:0]    n_b_reg, n_next;

    logic [N_W+RECIP_W-1:0] qp;
    logic [Q_W-1:0]         q0_reg, q0_next;
    logic                   neg_c_reg;
    logic [N_W-1:0]         n_c_reg;

    logic [N_W-1:0] back;
    logic [N_W-1:0] rem;
    logic [N_W-1:0] rem_fix;
    logic           fix;
    logic [Q_W-1:0] quo;
    sample_t        sample_reg, sample_next;

    // stall chain with bubble collapse
    always_comb
    begin
        hold[3] = v_reg[3] & out_stall;
        hold[2] = v_reg[2] & hold[3];
        hold[1] = v_reg[1] & hold[2];
        hold[0] = v_reg[0] & hold[1];
    end

    assign mix_stall = hold[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (!hold[0])
                v_reg[0] <= mix_valid;
            if (!hold[1])
                v_reg[1] <= v_reg[0];
            if (!hold[2])
                v_reg[2] <= v_reg[1];
            if (!hold[3])
                v_reg[3] <= v_reg[2];
        end
    end

    // mode flag travels alongside
    always_ff @(posedge clk)
    begin
        if (!hold[0])
            func_reg[0] <= mix_word.func;
        if (!hold[1])
            func_reg[1] <= func_reg[0];
        if (!hold[2])
            func_reg[2] <= func_reg[1];
        if (!hold[3])
            func_reg[3] <= func_reg[2];
    end

    // stage a: gain multiply, both modes share the divisor
    always_comb
    begin
        if (mix_word.func)
            gain = (GAIN_W + 1)'(CLOCK_GAIN);
        else
            gain = (GAIN_W + 1)'(DATA_GAIN);
        prod_next = mix_word.operand * gain;
    end

    always_ff @(posedge clk)
    begin
        if (!hold[0])
            prod_reg <= prod_next;
    end

    // stage b: magnitude, power-of-two part of the divisor dropped
    always_comb
    begin
        neg_next = prod_reg[PROD_W-1];
        mag = neg_next ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        n_next = mag[MAG_W-1:SCALE_POW];
    end

    always_ff @(posedge clk)
    begin
        if (!hold[1])
        begin
            neg_b_reg <= neg_next;
            n_b_reg   <= n_next;
        end
    end

    // stage c: quotient estimate by 43 via reciprocal, low by at most one
    always_comb
    begin
        qp = (N_W + RECIP_W)'(n_b_reg) * (N_W + RECIP_W)'(DIV_RECIP);
        q0_next = qp[DIV_SHIFT +: Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (!hold[2])
        begin
            q0_reg    <= q0_next;
            neg_c_reg <= neg_b_reg;
            n_c_reg   <= n_b_reg;
        end
    end

    // stage d: one correction step and the sign
    always_comb
    begin
        back = N_W'(q0_reg) * N_W'(SCALE_ODD);
        rem = n_c_reg - back;
        fix = (rem >= N_W'(SCALE_ODD));
        rem_fix = fix ? rem - N_W'(SCALE_ODD) : rem;
        quo = q0_reg + Q_W'(fix);
        sample_next = neg_c_reg ? -sample_t'(quo) : sample_t'(quo);
    end

    always_ff @(posedge clk)
    begin
        if (!hold[3])
            sample_reg <= sample_next;
    end

    assign out_valid    = v_reg[3];
    assign audio_sample = sample_reg;

    // corrected remainder lies below the odd divisor
    `MTBM_ASSERT_IMP(a_rem_range, v_reg[2], rem_fix < N_W'(SCALE_ODD))
    // clock-mode words never exceed the clock amplitude
    `MTBM_ASSERT_IMP(a_clock_bound, v_reg[3] && func_reg[3], (sample_reg <= 16'sd3270) && (sample_reg >= -16'sd3270))

endmodule
